### rtl/core/pcb_pkg.sv
// Shared types and constants for the pixel color boost block.
// Holds field widths, register codes, reset values and the noise generator
// constants. No dependencies.
package pcb_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 32;
  localparam int GAIN_W = 12;
  localparam int EG_W   = GAIN_W + 1;
  localparam int LVL_W  = 9;
  localparam int SEED_W = 32;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam logic [GAIN_W-1:0] BRIGHT_RST   = 12'd333;
  localparam logic [GAIN_W-1:0] CONTRAST_RST = 12'd512;
  localparam logic [GAIN_W-1:0] SAT_RST      = 12'd768;
  localparam logic [LVL_W-1:0]  LEVEL_RST    = 9'd38;
  localparam logic [LVL_W-1:0]  LEVEL_MAX    = 9'd256;
  localparam logic [SEED_W-1:0] SEED_RST     = 32'hDEADBEEF;

  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd12345;

  localparam int LUMA_R = 77;
  localparam int LUMA_G = 150;
  localparam int LUMA_B = 29;
  localparam int LUMA_SHIFT = 8;
  localparam int NOISE_SHIFT = 8;
  localparam int MID_LEVEL = 128;
  localparam int MAX_LEVEL = 255;

  typedef enum logic [2:0] {
    REG_BRIGHT   = 3'd0,
    REG_CONTRAST = 3'd1,
    REG_SAT      = 3'd2,
    REG_LEVEL    = 3'd3,
    REG_SEED     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [EG_W-1:0]  bright;
    logic [EG_W-1:0]  contrast;
    logic [EG_W-1:0]  sat;
    logic [LVL_W-1:0] level;
  } gains_t;

  typedef struct packed {
    logic              load;
    logic [SEED_W-1:0] seed;
    logic              enable;
  } noise_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CH_W-1:0]  noise_byte;
  } q_item_t;

endpackage

### rtl/core/pcb_regs.sv
// Configuration registers behind the APB-style port, with readback.
// Produces the effective gains and the noise generator controls.
// Depends on pcb_pkg.
module pcb_regs #(
  parameter int GAIN_FRAC_BITS = pcb_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcb_pkg::ADDR_W-1:0] paddr,
  input  logic [pcb_pkg::DATA_W-1:0] pwdata,
  output logic [pcb_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output pcb_pkg::gains_t           gains_o,
  output pcb_pkg::noise_ctl_t       noise_ctl_o
);
  import pcb_pkg::*;

  localparam logic [EG_W-1:0] UNITY = EG_W'(1 << GAIN_FRAC_BITS);

  logic [GAIN_W-1:0] bright_q, contrast_q, sat_q;
  logic [LVL_W-1:0]  level_q;
  logic [SEED_W-1:0] seed_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q   <= BRIGHT_RST;
      contrast_q <= CONTRAST_RST;
      sat_q      <= SAT_RST;
      level_q    <= LEVEL_RST;
      seed_q     <= SEED_RST;
    end else if (wr_en) begin
      case (idx)
        REG_BRIGHT:   bright_q   <= pwdata[GAIN_W-1:0];
        REG_CONTRAST: contrast_q <= pwdata[GAIN_W-1:0];
        REG_SAT:      sat_q      <= pwdata[GAIN_W-1:0];
        REG_LEVEL:    level_q    <= pwdata[LVL_W-1:0];
        REG_SEED:     seed_q     <= pwdata[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BRIGHT:   prdata = DATA_W'(bright_q);
      REG_CONTRAST: prdata = DATA_W'(contrast_q);
      REG_SAT:      prdata = DATA_W'(sat_q);
      REG_LEVEL:    prdata = DATA_W'(level_q);
      REG_SEED:     prdata = DATA_W'(seed_q);
      default:      prdata = '0;
    endcase
  end

  // A gain of zero acts as unity; a level above full scale saturates.
  always_comb begin
    gains_o.bright   = (bright_q == '0)   ? UNITY : {1'b0, bright_q};
    gains_o.contrast = (contrast_q == '0) ? UNITY : {1'b0, contrast_q};
    gains_o.sat      = (sat_q == '0)      ? UNITY : {1'b0, sat_q};
    gains_o.level    = (level_q > LEVEL_MAX) ? LEVEL_MAX : level_q;
    noise_ctl_o.load   = wr_en && (idx == REG_SEED);
    noise_ctl_o.seed   = pwdata[SEED_W-1:0];
    noise_ctl_o.enable = (level_q != '0);
  end

endmodule

### rtl/core/pcb_front.sv
// Front end: accepts pixels, steps the noise generator while noise is enabled and tags each
// pixel with its noise byte before it enters the queue.
// Depends on pcb_pkg.
module pcb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pcb_pkg::PIX_W-1:0]  pixel_in_i,
  input  pcb_pkg::noise_ctl_t        noise_ctl_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output pcb_pkg::q_item_t           q_item_o
);
  import pcb_pkg::*;

  logic [SEED_W-1:0] gen_q, gen_d, gen_next;
  logic              accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign gen_next   = gen_q * LCG_MUL + LCG_ADD;

  always_comb begin
    gen_d = gen_q;
    if (noise_ctl_i.load) begin
      gen_d = noise_ctl_i.seed;
    end else if (accept && noise_ctl_i.enable) begin
      gen_d = gen_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= SEED_RST;
    end else begin
      gen_q <= gen_d;
    end
  end

  assign q_push_o            = accept;
  assign q_item_o.pixel      = pixel_in_i;
  assign q_item_o.noise_byte = gen_next[CH_W-1:0];

endmodule

### rtl/core/pcb_queue.sv
// Short queue between the front end and the processing pipeline.
// Depends on pcb_pkg.
module pcb_queue #(
  parameter int DEPTH = pcb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pcb_pkg::q_item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output pcb_pkg::q_item_t item_o
);
  import pcb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  q_item_t           mem_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

### rtl/core/pcb_back.sv
// Processing pipeline: brightness and contrast, luma, saturation, noise
// and clamp, ending in the output register. Stalls as a whole.
// Depends on pcb_pkg.
module pcb_back #(
  parameter int GAIN_FRAC_BITS = pcb_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  pcb_pkg::q_item_t          q_item_i,
  output logic                      q_pop_o,
  input  pcb_pkg::gains_t           gains_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pcb_pkg::PIX_W-1:0] pixel_out_o
);
  import pcb_pkg::*;

  localparam int F    = GAIN_FRAC_BITS;
  localparam int D_W  = CH_W + EG_W + 1;
  localparam int C_W  = D_W + EG_W + 1;
  localparam int W_W  = C_W + 10;
  localparam int DF_W = C_W + 1;
  localparam int P_W  = DF_W + EG_W + 1;
  localparam int T_W  = P_W + 1;
  localparam int NP_W = LVL_W + 11;
  localparam int N_W  = NP_W + F;
  localparam int MID_I = MID_LEVEL << F;
  localparam int HI_I  = MAX_LEVEL << F;

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q, ov_q;

  logic signed [D_W-1:0]  d1_q [3];
  logic signed [D_W-1:0]  d1_d [3];
  logic signed [C_W-1:0]  c2_q [3];
  logic signed [C_W-1:0]  c2_d [3];
  logic signed [C_W-1:0]  c3_q [3];
  logic signed [C_W-1:0]  g3_q, g3_d;
  logic signed [W_W-1:0]  wsum;
  logic signed [P_W-1:0]  p4_q [3];
  logic signed [P_W-1:0]  p4_d [3];
  logic signed [C_W-1:0]  g4_q;
  logic signed [N_W-1:0]  n1_q, n1_d, n2_q, n3_q, n4_q;
  logic [CH_W-1:0]        a1_q, a2_q, a3_q, a4_q;
  logic [CH_W-1:0]        res [3];
  logic [PIX_W-1:0]       pix_q, pix_d;

  logic signed [CH_W:0]   nb;
  logic signed [NP_W-1:0] nprod;
  logic signed [N_W-1:0]  nwide;

  assign adv     = !ov_q || out_ready_i;
  assign q_pop_o = adv && q_valid_i;

  always_comb begin
    logic [D_W-2:0]       b;
    logic signed [C_W-1:0] cp;
    logic signed [DF_W-1:0] diff;
    logic signed [T_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      b = q_item_i.pixel[i*CH_W +: CH_W] * gains_i.bright;
      d1_d[i] = $signed({1'b0, b}) - D_W'(MID_I);
      cp = d1_q[i] * $signed({1'b0, gains_i.contrast});
      c2_d[i] = (cp >>> F) + C_W'(MID_I);
      diff = DF_W'(c3_q[i]) - DF_W'(g3_q);
      p4_d[i] = diff * $signed({1'b0, gains_i.sat});
      t = T_W'(g4_q) + T_W'(p4_q[i] >>> F) + T_W'(n4_q);
      if (t < 0) begin
        res[i] = '0;
      end else if (t > T_W'(HI_I)) begin
        res[i] = CH_W'(MAX_LEVEL);
      end else begin
        res[i] = t[F +: CH_W];
      end
    end
    wsum = W_W'(c2_q[0]) * W_W'(LUMA_R) + W_W'(c2_q[1]) * W_W'(LUMA_G)
         + W_W'(c2_q[2]) * W_W'(LUMA_B);
    g3_d = C_W'(wsum >>> LUMA_SHIFT);
  end

  assign nb    = $signed({1'b0, q_item_i.noise_byte}) - (CH_W+1)'(MID_LEVEL);
  assign nprod = (nb * $signed({1'b0, gains_i.level})) <<< 1;
  assign nwide = N_W'(nprod) <<< F;
  assign n1_d  = nwide >>> NOISE_SHIFT;
  assign pix_d = {a4_q, res[2], res[1], res[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= q_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= d1_d[i];
        c2_q[i] <= c2_d[i];
        c3_q[i] <= c2_q[i];
        p4_q[i] <= p4_d[i];
      end
      a1_q  <= q_item_i.pixel[PIX_W-1 -: CH_W];
      a2_q  <= a1_q;
      a3_q  <= a2_q;
      a4_q  <= a3_q;
      n1_q  <= n1_d;
      n2_q  <= n1_q;
      n3_q  <= n2_q;
      n4_q  <= n3_q;
      g3_q  <= g3_d;
      g4_q  <= g3_q;
      pix_q <= pix_d;
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_out_o = pix_q;

endmodule

### rtl/core/pixel_color_boost_with_noise.sv
// Top level of the pixel color boost block with additive noise.
// Instantiates pcb_regs, pcb_front, pcb_queue and pcb_back; uses pcb_pkg.
//
// The block takes one RGBA pixel per clock and returns one processed pixel
// per clock while the output is not stalled, in order, with alpha unchanged.
// A result shows on the output after its pixel has passed the queue and the
// processing pipeline stages d1, c2, c3 and p4, after which it is held in
// the output register until it is taken. The sustained rate of one pixel per
// cycle is set by the noise generator, whose multiply-add closes a loop
// through a single register in the front end. While the output is stalled,
// the queue keeps taking pixels until it fills.
module pixel_color_boost_with_noise #(
  parameter int GAIN_FRAC_BITS = pcb_pkg::GAIN_FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH    = pcb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcb_pkg::ADDR_W-1:0] paddr,
  input  logic [pcb_pkg::DATA_W-1:0] pwdata,
  output logic [pcb_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [pcb_pkg::PIX_W-1:0]  pixel_in_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [pcb_pkg::PIX_W-1:0]  pixel_out_o
);
  import pcb_pkg::*;

  gains_t     gains;
  noise_ctl_t noise_ctl;
  q_item_t    push_item, head_item;
  logic       q_full, q_push, q_valid, q_pop;

  pcb_regs #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .gains_o    (gains),
    .noise_ctl_o(noise_ctl)
  );

  pcb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_in_i (pixel_in_i),
    .noise_ctl_i(noise_ctl),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  pcb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (head_item)
  );

  pcb_back #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (head_item),
    .q_pop_o    (q_pop),
    .gains_i    (gains),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o)
  );

endmodule

### rtl/core/pcb_checker.sv
// Port-level checks for the pixel color boost block, bound to its top level.
// Tracks words in flight and register readback. Depends on pcb_pkg.
module pcb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [pcb_pkg::ADDR_W-1:0] paddr,
  input logic [pcb_pkg::DATA_W-1:0] pwdata,
  input logic [pcb_pkg::DATA_W-1:0] prdata,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [pcb_pkg::PIX_W-1:0]  pixel_out_o
);
  import pcb_pkg::*;

  logic [7:0] pending_q;
  logic       in_acc, out_acc, wr_bright;

  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign wr_bright = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_BRIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o))
    else $error("Output word dropped or changed while stalled.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("Output word shown with no input word in flight.");

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pending_q != '0)
    else $error("Input held off while the block is empty.");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_bright ##1 (paddr[ADDR_W-1:2] == REG_BRIGHT)
      |-> prdata[GAIN_W-1:0] == $past(pwdata[GAIN_W-1:0]))
    else $error("Brightness register readback does not match the write.");

endmodule

bind pixel_color_boost_with_noise pcb_checker u_pcb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .pixel_out_o(pixel_out_o)
);

### tb/sv/tb_pixel_color_boost_with_noise.sv
// Self-checking testbench for pixel_color_boost_with_noise: drives pixels and register
// writes, predicts each processed pixel and compares it with the block's output.
// Depends on pcb_pkg and the pixel_color_boost_with_noise RTL.
module tb_pixel_color_boost_with_noise;
  timeunit 1ns;
  timeprecision 1ps;

  import pcb_pkg::*;

  localparam int FRAC        = GAIN_FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 500;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [DATA_W-1:0] pwdata      = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [PIX_W-1:0]  pixel_in_i  = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b1;
  logic [PIX_W-1:0]  pixel_out_o;

  logic [GAIN_W-1:0] gain_bright   = BRIGHT_RST;
  logic [GAIN_W-1:0] gain_contrast = CONTRAST_RST;
  logic [GAIN_W-1:0] gain_sat      = SAT_RST;
  logic [LVL_W-1:0]  noise_lvl     = LEVEL_RST;
  logic [SEED_W-1:0] lcg_state     = SEED_RST;

  logic [PIX_W-1:0] expected_pixels[$];
  bit gaps_on  = 1'b0;
  bit stall_on = 1'b0;
  int pixels_sent    = 0;
  int pixels_checked = 0;
  int settings_used  = 1;
  int mismatches     = 0;
  int idle_cycles    = 0;

  pixel_color_boost_with_noise #(
    .GAIN_FRAC_BITS(FRAC)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_in_i (pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pixel_out_o(pixel_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [PIX_W-1:0] boost_pixel(input logic [PIX_W-1:0] px);
    longint one, mid, bg, cg, sg, gray, noise_add, n, t, v, top;
    longint ch[3];
    logic [CH_W-1:0] res[3];
    logic [LVL_W-1:0] lvl;
    one = longint'(1) << FRAC;
    mid = MID_LEVEL * one;
    top = MAX_LEVEL * one;
    bg = (gain_bright == 0) ? one : longint'(gain_bright);
    cg = (gain_contrast == 0) ? one : longint'(gain_contrast);
    sg = (gain_sat == 0) ? one : longint'(gain_sat);
    for (int i = 0; i < 3; i++) begin
      v = longint'(px[CH_W*i +: CH_W]) * bg;
      ch[i] = (((v - mid) * cg) >>> FRAC) + mid;
    end
    gray = (LUMA_R * ch[0] + LUMA_G * ch[1] + LUMA_B * ch[2]) >>> LUMA_SHIFT;
    for (int i = 0; i < 3; i++) begin
      ch[i] = gray + (((ch[i] - gray) * sg) >>> FRAC);
    end
    lvl = (noise_lvl > LEVEL_MAX) ? LEVEL_MAX : noise_lvl;
    noise_add = 0;
    if (lvl != 0) begin
      lcg_state = lcg_state * LCG_MUL + LCG_ADD;
      n = (longint'(lcg_state[CH_W-1:0]) - MID_LEVEL) * 2 * longint'(lvl);
      noise_add = (n * one) >>> NOISE_SHIFT;
    end
    for (int i = 0; i < 3; i++) begin
      t = ch[i] + noise_add;
      if (t < 0) t = 0;
      if (t > top) t = top;
      res[i] = CH_W'(t >>> FRAC);
    end
    return {px[PIX_W-1:3*CH_W], res[2], res[1], res[0]};
  endfunction

  function automatic logic [DATA_W-1:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 4095;
      3: return 256;
      default: return $urandom_range(1, 4095);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return LEVEL_MAX;
      2: return $urandom_range(257, 511);
      3: return 1;
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] px;
    px = $urandom();
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 7))
        0: px[CH_W*i +: CH_W] = '0;
        1: px[CH_W*i +: CH_W] = '1;
        default: ;
      endcase
    end
    return px;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BRIGHT:   gain_bright = value[GAIN_W-1:0];
      REG_CONTRAST: gain_contrast = value[GAIN_W-1:0];
      REG_SAT:      gain_sat = value[GAIN_W-1:0];
      REG_LEVEL:    noise_lvl = value[LVL_W-1:0];
      REG_SEED:     lcg_state = value[SEED_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(boost_pixel(px));
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_gains(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] c,
                           input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] lvl);
    wait_idle();
    write_reg(REG_BRIGHT, b);
    write_reg(REG_CONTRAST, c);
    write_reg(REG_SAT, s);
    write_reg(REG_LEVEL, lvl);
    settings_used++;
  endtask

  task automatic test_reset_values();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8080_8080);
    send_pixel(32'h1234_5678);
  endtask

  // Zero gains act as unity, so with noise off the colors come back untouched.
  task automatic test_unity_gains();
    set_gains(0, 0, 0, 0);
    send_pixel(32'hA5FF_0080);
    send_pixel(32'h00FF_00FF);
    send_pixel(32'hFF00_FF00);
  endtask

  task automatic test_noise_levels();
    send_pixel(32'h4080_C010);
    send_pixel(32'h4080_C010);
    set_gains(256, 256, 256, 1);
    send_pixel(32'h3377_BB11);
    send_pixel(32'h3377_BB11);
    set_gains(256, 256, 256, 511);
    send_pixel(32'h8080_8080);
    send_pixel(32'h00FF_7F01);
    set_gains(256, 256, 256, LEVEL_MAX);
    send_pixel(32'h8080_8080);
  endtask

  task automatic test_extreme_gains();
    set_gains(4095, 4095, 4095, LEVEL_MAX);
    write_reg(REG_SEED, 32'h0000_0000);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h7F80_8180);
    send_pixel(32'h0001_0203);
    set_gains(1, 1, 1, 0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0080_FF00);
    set_gains(1, 4095, 1, 128);
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    send_pixel(32'hC0FF_0040);
    send_pixel(32'h01FE_80A0);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      set_gains(rand_gain(), rand_gain(), rand_gain(), rand_level());
      if ($urandom_range(0, 1) == 1) write_reg(REG_SEED, $urandom());
      for (int k = 0; k < per_phase; k++) send_pixel(random_pixel());
    end
  endtask

  task automatic test_steady_stream(input int count);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    set_gains(rand_gain(), rand_gain(), rand_gain(), $urandom_range(1, 255));
    write_reg(REG_SEED, $urandom());
    for (int k = 0; k < count; k++) send_pixel(random_pixel());
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      if (stall_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [PIX_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_out: no pixel pending, actual %h", pixel_out_o);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (pixel_out_o !== want) begin
          $error("pixel_out: expected %h, actual %h", want, pixel_out_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb_pixel_color_boost_with_noise NOT OK");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_reset_values();
    test_unity_gains();
    test_noise_levels();
    test_extreme_gains();
    test_random_settings(7, 100);
    test_steady_stream(100);
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d pixels under %0d register settings, %0d results compared.",
             pixels_sent, settings_used, pixels_checked);
    if (mismatches == 0) begin
      $display("tb_pixel_color_boost_with_noise OK");
    end else begin
      $display("tb_pixel_color_boost_with_noise NOT OK");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/pcb_pkg.sv
rtl/core/pcb_regs.sv
rtl/core/pcb_front.sv
rtl/core/pcb_queue.sv
rtl/core/pcb_back.sv
rtl/core/pixel_color_boost_with_noise.sv
rtl/core/pcb_checker.sv
tb/sv/tb_pixel_color_boost_with_noise.sv
